### rtl/u8d_pkg.sv
// Shared types, constants and the sequence classifier for the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    // Scalar value limits
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;

    // Output beat layout
    localparam int TDATA_W = 56;
    localparam int TUSER_W = 2;
    localparam int TOTAL_W = 16;

    // Result kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_SKIP   = 2'd1,
        KIND_TOTALS = 2'd2
    } kind_t;

    // What the head of the byte buffer resolves to
    typedef enum logic [1:0] {
        ACT_EMPTY,
        ACT_WAIT,
        ACT_POINT,
        ACT_SKIP
    } act_t;

    typedef struct packed {
        act_t        act;
        logic [2:0]  len;    // bytes consumed by this action
        logic [20:0] value;  // code point, or the lead byte on a skip
    } eval_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic       eot;     // zero byte: end of text
        logic [7:0] data;
    } tok_t;

    // Resolve the head of a buffer of up to four bytes (byte 0 in the low bits)
    function automatic eval_t u8d_eval(input logic [31:0] bytes, input logic [2:0] cnt);
        logic [7:0]  c;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  n;
        logic [20:0] v;
        logic [20:0] minv;
        logic        lead;
        logic        bad;
        eval_t       e;
        c    = bytes[7:0];
        b1   = bytes[15:8];
        b2   = bytes[23:16];
        b3   = bytes[31:24];
        n    = 3'd1;
        v    = {13'd0, c};
        minv = MIN_TWO;
        lead = 1'b1;
        if (c[7:5] == 3'b110)
        begin
            n    = 3'd2;
            v    = {10'd0, c[4:0], b1[5:0]};
            minv = MIN_TWO;
        end
        else if (c[7:4] == 4'b1110)
        begin
            n    = 3'd3;
            v    = {5'd0, c[3:0], b1[5:0], b2[5:0]};
            minv = MIN_THREE;
        end
        else if (c[7:3] == 5'b11110)
        begin
            n    = 3'd4;
            v    = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
            minv = MIN_FOUR;
        end
        else
        begin
            lead = 1'b0;
        end
        // Continuations are checked only as far as they have arrived
        bad = (cnt > 3'd1 && b1[7:6] != 2'b10)
            || (n > 3'd2 && cnt > 3'd2 && b2[7:6] != 2'b10)
            || (n > 3'd3 && cnt > 3'd3 && b3[7:6] != 2'b10);
        e.act   = ACT_SKIP;
        e.len   = 3'd1;
        e.value = {13'd0, c};
        if (cnt == 3'd0)
        begin
            e.act = ACT_EMPTY;
        end
        else if (!c[7])
        begin
            e.act = ACT_POINT;
        end
        else if (lead)
        begin
            if (!bad && cnt < n)
            begin
                e.act = ACT_WAIT;
            end
            else if (!bad && !(v < minv || v > MAX_SCALAR || (v >= SURR_LO && v <= SURR_HI)))
            begin
                e.act   = ACT_POINT;
                e.len   = n;
                e.value = v;
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/u8d_front.sv
// Front end: accept text bytes, tag end of text, and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output      logic       s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    output      logic       tok_valid,
    input  wire logic       tok_ready,
    output      tok_t       tok
);

    localparam int DEPTH = 2;

    tok_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    tok_t       in_tok;

    // Classify the incoming beat
    always_comb
    begin
        in_tok.eot  = (s_axis_tdata == 8'd0);
        in_tok.data = s_axis_tdata;
    end

    assign s_axis_tready = (count_reg != 2'(DEPTH));
    assign tok_valid     = (count_reg != 2'd0);
    assign tok           = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = tok_valid && tok_ready;

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

`default_nettype wire

### rtl/u8d_back.sv
// Back end: sequence buffer, validation, counters and the registered result beat.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tok_valid,
    output      logic                 tok_ready,
    input  wire tok_t                 tok,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [TDATA_W-1:0]   m_axis_tdata,
    output      logic [TUSER_W-1:0]   m_axis_tuser,
    output      logic                 m_axis_tlast
);

    localparam int EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [EXT_W-1:0] SHOW_MAX = EXT_W'({TOTAL_W{1'b1}});

    logic [31:0]            buf_reg, buf_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   settled_reg, settled_next;
    logic                   eot_reg, eot_next;
    logic [COUNT_WIDTH-1:0] points_reg, points_next;
    logic [COUNT_WIDTH-1:0] skips_reg, skips_next;
    logic [15:0]            limit_reg;

    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [20:0]            out_cp_reg;
    logic                   out_lim_reg;
    logic [15:0]            out_pt_reg;
    logic [15:0]            out_st_reg;
    logic                   out_last_reg;

    logic                   load;
    kind_t                  res_kind;
    logic [20:0]            res_cp;
    logic                   res_lim;
    logic [15:0]            res_pt;
    logic [15:0]            res_st;
    logic                   res_last;

    logic                   pop;
    logic                   out_free;
    logic [31:0]            work_buf;
    logic [2:0]             work_cnt;
    logic [2:0]             drop_n;
    logic [31:0]            drop_buf;
    logic [2:0]             drop_cnt;
    eval_t                  e_now;
    eval_t                  e_after;
    logic                   now_emits;
    logic                   after_emits;
    logic [COUNT_WIDTH-1:0] points_inc;
    logic [COUNT_WIDTH-1:0] skips_inc;

    function automatic logic [15:0] show(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > SHOW_MAX) ? {TOTAL_W{1'b1}} : ext[15:0];
    endfunction

    function automatic logic [31:0] append(input logic [31:0] b, input logic [2:0] cnt,
                                           input logic [7:0] d);
        logic [31:0] r;
        r = b;
        case (cnt)
            3'd0:    r[7:0]   = d;
            3'd1:    r[15:8]  = d;
            3'd2:    r[23:16] = d;
            default: r[31:24] = d;
        endcase
        return r;
    endfunction

    // Take a byte only when the buffer is waiting on more input
    assign tok_ready = settled_reg && !eot_reg;
    assign pop       = tok_valid && tok_ready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Form the working buffer and resolve its head, then the head after the drop
    always_comb
    begin
        work_buf = buf_reg;
        work_cnt = cnt_reg;
        if (pop && !tok.eot)
        begin
            work_buf = append(buf_reg, cnt_reg, tok.data);
            work_cnt = cnt_reg + 3'd1;
        end
        e_now       = u8d_eval(work_buf, work_cnt);
        now_emits   = (e_now.act == ACT_POINT) || (e_now.act == ACT_SKIP);
        drop_n      = eot_reg ? 3'd1 : e_now.len;
        drop_buf    = work_buf >> {drop_n, 3'b000};
        drop_cnt    = work_cnt - drop_n;
        e_after     = u8d_eval(drop_buf, drop_cnt);
        after_emits = (e_after.act == ACT_POINT) || (e_after.act == ACT_SKIP);
        points_inc  = (points_reg == COUNT_MAX) ? points_reg : points_reg + 1'b1;
        skips_inc   = (skips_reg == COUNT_MAX) ? skips_reg : skips_reg + 1'b1;
    end

    // Next state of buffer and counters
    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        settled_next = settled_reg;
        eot_next     = eot_reg;
        points_next  = points_reg;
        skips_next   = skips_reg;
        if (eot_reg)
        begin
            settled_next = 1'b1;
            if (out_free)
            begin
                if (cnt_reg != 3'd0)
                begin
                    buf_next   = drop_buf;
                    cnt_next   = drop_cnt;
                    skips_next = skips_inc;
                end
                else
                begin
                    eot_next    = 1'b0;
                    points_next = '0;
                    skips_next  = '0;
                end
            end
        end
        else
        begin
            if (pop && tok.eot)
            begin
                eot_next = 1'b1;
            end
            buf_next     = work_buf;
            cnt_next     = work_cnt;
            settled_next = !now_emits;
            if (now_emits && out_free)
            begin
                buf_next     = drop_buf;
                cnt_next     = drop_cnt;
                settled_next = !after_emits;
                if (e_now.act == ACT_POINT)
                begin
                    points_next = points_inc;
                end
                else
                begin
                    skips_next = skips_inc;
                end
            end
        end
    end

    // Build the result beat
    always_comb
    begin
        load     = 1'b0;
        res_kind = KIND_SKIP;
        res_cp   = {13'd0, buf_reg[7:0]};
        res_lim  = 1'b0;
        res_pt   = show(points_reg);
        res_st   = show(skips_inc);
        res_last = 1'b0;
        if (eot_reg)
        begin
            load = out_free;
            if (cnt_reg == 3'd0)
            begin
                res_kind = KIND_TOTALS;
                res_cp   = '0;
                res_st   = show(skips_reg);
                res_last = 1'b1;
            end
        end
        else if (now_emits)
        begin
            load     = out_free;
            res_cp   = e_now.value;
            res_last = !after_emits;
            if (e_now.act == ACT_POINT)
            begin
                res_kind = KIND_POINT;
                res_lim  = (EXT_W'(points_reg) < EXT_W'(limit_reg));
                res_pt   = show(points_inc);
                res_st   = show(skips_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= 3'd0;
            settled_reg   <= 1'b1;
            eot_reg       <= 1'b0;
            points_reg    <= '0;
            skips_reg     <= '0;
            limit_reg     <= 16'd512;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            settled_reg <= settled_next;
            eot_reg     <= eot_next;
            points_reg  <= points_next;
            skips_reg   <= skips_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= res_kind;
            out_cp_reg   <= res_cp;
            out_lim_reg  <= res_lim;
            out_pt_reg   <= res_pt;
            out_st_reg   <= res_st;
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_st_reg, out_pt_reg, out_lim_reg, out_cp_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // A buffer waiting on input never holds a complete four-byte sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (settled_reg && !eot_reg) |-> (cnt_reg <= 3'd3))
        else $error("settled buffer holds too many bytes");

    // Totals clear the counters and the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_kind == KIND_TOTALS) |=>
            (points_reg == '0 && skips_reg == '0 && cnt_reg == 3'd0 && !eot_reg))
        else $error("counters not cleared after totals");

    // A totals beat always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_TOTALS) |-> out_last_reg)
        else $error("totals beat without last");

    // No byte is taken while the end of text is being flushed
    assert property (@(posedge clk) disable iff (!rst_n)
        eot_reg |-> !(tok_valid && tok_ready))
        else $error("byte taken during flush");

endmodule

`default_nettype wire

### rtl/utf8_validating_decoder.sv
// Top level of the streaming UTF-8 validating decoder.
// One text byte enters per beat and results leave as beats carrying a kind on tuser
// (decoded code point, skipped malformed byte, end-of-text totals) with tlast on the
// final result caused by each input byte. A byte that yields at most one result, or
// extends a pending sequence, leaves input flowing, so clean text runs at one byte per
// clock while the result side is ready; a byte that exposes an error yields one result
// per cycle while the result side is ready. A zero byte is registered as end of text,
// then each pending byte is flushed as a skip, then the totals beat is sent. The single
// result stage of the back end holds each result; a two-beat queue ahead of it keeps
// input flowing while a result waits. store_limit resets to 512 and is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module utf8_validating_decoder
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output      logic               s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // text_byte
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output      logic [TDATA_W-1:0] m_axis_tdata,   // code_point, within_limit,
                                                    // point_total, skip_total, zero pad
    output      logic [TUSER_W-1:0] m_axis_tuser,   // kind
    output      logic               m_axis_tlast,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data     // store_limit
);

    logic tok_valid;
    logic tok_ready;
    tok_t tok;

    // Accept and classify bytes
    u8d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .tok           (tok)
    );

    // Decode, validate and count
    u8d_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .tok           (tok),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### tb/utf8_decode_checker.sv
// Checker for the UTF-8 decoder: watches both streams, predicts results and compares them.
`timescale 1ns / 1ps

module utf8_decode_checker
    import u8d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic [TUSER_W-1:0] m_axis_tuser,
    input  wire logic               m_axis_tlast,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    output int                      mismatch_count,
    output int                      results_owed
);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        kind_t       kind;
        logic [20:0] code_point;
        logic        within_limit;
        logic [15:0] point_total;
        logic [15:0] skip_total;
        logic        last_of_run;
    } decoded_t;

    // Decoder state as the block should hold it
    logic [7:0]  held_bytes [0:2];
    logic [1:0]  held_count  = 2'd0;
    logic [15:0] point_count = 16'd0;
    logic [15:0] skip_count  = 16'd0;
    logic [15:0] store_limit = 16'd512;
    decoded_t    owed_results [$];

    function automatic decoded_t make_result(input kind_t k, input logic [20:0] cp,
                                             input logic wl);
        decoded_t r;
        r.kind         = k;
        r.code_point   = cp;
        r.within_limit = wl;
        r.point_total  = point_count;
        r.skip_total   = skip_count;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic log_skip(input logic [7:0] b);
        if (skip_count != COUNT_MAX)
            skip_count = skip_count + 16'd1;
        owed_results.push_back(make_result(KIND_SKIP, {13'd0, b}, 1'b0));
    endtask

    task automatic log_point(input logic [20:0] cp);
        logic wl;
        // index test uses the count before this point, saturated or not
        wl = (point_count < store_limit);
        if (point_count != COUNT_MAX)
            point_count = point_count + 16'd1;
        owed_results.push_back(make_result(KIND_POINT, cp, wl));
    endtask

    // Work out every result that one accepted text byte causes
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0]  work [0:3];
        logic [7:0]  lead;
        logic [20:0] acc;
        logic [20:0] floor_val;
        logic        bad;
        logic        waiting;
        decoded_t    tail;
        int          fill;
        int          need;
        int          shift;
        int          i;
        int          before_count;
        before_count = owed_results.size();
        for (i = 0; i < 3; i++)
            work[i] = held_bytes[i];
        work[3] = 8'h00;
        fill = int'(held_count);
        if (b == 8'h00)
        begin
            // end of text: flush pending bytes, report totals, clear counters
            for (i = 0; i < fill; i++)
                log_skip(work[i]);
            owed_results.push_back(make_result(KIND_TOTALS, 21'd0, 1'b0));
            point_count = 16'd0;
            skip_count  = 16'd0;
            held_count  = 2'd0;
        end
        else
        begin
            work[fill] = b;
            fill = fill + 1;
            waiting = 1'b0;
            while (fill > 0 && !waiting)
            begin
                lead      = work[0];
                need      = 1;
                acc       = {13'd0, lead};
                floor_val = MIN_TWO;
                bad       = 1'b0;
                if (lead[7:5] == 3'b110)
                begin
                    need      = 2;
                    acc       = {16'd0, lead[4:0]};
                    floor_val = MIN_TWO;
                end
                else if (lead[7:4] == 4'b1110)
                begin
                    need      = 3;
                    acc       = {17'd0, lead[3:0]};
                    floor_val = MIN_THREE;
                end
                else if (lead[7:3] == 5'b11110)
                begin
                    need      = 4;
                    acc       = {18'd0, lead[2:0]};
                    floor_val = MIN_FOUR;
                end
                else if (lead[7])
                    bad = 1'b1;   // stray continuation or lead F8..FF
                // check continuations only as far as they have arrived
                for (i = 1; i < need && i < fill && !bad; i++)
                begin
                    if (work[i][7:6] != 2'b10)
                        bad = 1'b1;
                    else
                        acc = {acc[14:0], work[i][5:0]};
                end
                if (!bad && fill < need)
                    waiting = 1'b1;
                else
                begin
                    // range, overlong and surrogate checks once the sequence is whole
                    if (!bad && need > 1 && (acc < floor_val || acc > MAX_SCALAR
                        || (acc >= SURR_LO && acc <= SURR_HI)))
                        bad = 1'b1;
                    if (bad)
                    begin
                        log_skip(lead);
                        shift = 1;
                    end
                    else
                    begin
                        log_point(acc);
                        shift = need;
                    end
                    for (i = 0; i + shift < fill; i++)
                        work[i] = work[i + shift];
                    fill = fill - shift;
                end
            end
            for (i = 0; i < fill; i++)
                held_bytes[i] = work[i];
            held_count = fill[1:0];
        end
        // mark the final result of this byte
        if (owed_results.size() > before_count)
        begin
            tail = owed_results.pop_back();
            tail.last_of_run = 1'b1;
            owed_results.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        decoded_t want;
        decoded_t seen;
        if (!rst_n)
        begin
            held_count  = 2'd0;
            point_count = 16'd0;
            skip_count  = 16'd0;
            store_limit = 16'd512;
            owed_results.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end
        else
        begin
            // track the limit register and predict from each input beat
            if (cfg_wr_en)
                store_limit = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            // compare each output beat with the oldest owed result
            if (m_axis_tvalid && m_axis_tready)
            begin
                // tdata: code_point, within_limit, point_total, skip_total, pad
                seen.kind         = kind_t'(m_axis_tuser);
                seen.code_point   = m_axis_tdata[20:0];
                seen.within_limit = m_axis_tdata[21];
                seen.point_total  = m_axis_tdata[37:22];
                seen.skip_total   = m_axis_tdata[53:38];
                seen.last_of_run  = m_axis_tlast;
                if (owed_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected beat kind %0d cp %h within %0b points %0d",
                                 $time, seen.kind, seen.code_point, seen.within_limit,
                                 seen.point_total, " skips %0d last %0b",
                                 seen.skip_total, seen.last_of_run);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("%0t: exp/got kind %0d/%0d cp %h/%h within %0b/%0b",
                                     $time, want.kind, seen.kind, want.code_point,
                                     seen.code_point, want.within_limit, seen.within_limit,
                                     " points %0d/%0d skips %0d/%0d last %0b/%0b",
                                     want.point_total, seen.point_total, want.skip_total,
                                     seen.skip_total, want.last_of_run, seen.last_of_run);
                    end
                end
            end
            results_owed <= owed_results.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the UTF-8 decoder testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;

    import u8d_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;
    logic               m_axis_tlast;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;

    logic               src_idle_en;
    logic               sink_idle_en;
    logic               hold_req;
    int                 mismatch_count;
    int                 results_owed;
    int unsigned        cycle_count = 0;

    // Opening text: extremes, two- and four-byte sequences, each kind of rejection, flush on end
    logic [7:0] opening_text [0:23] = '{
        8'h41, 8'h7F,
        8'hC3, 8'hA9,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'h80, 8'hFF,
        8'hE2, 8'h41,
        8'hC0, 8'h80,
        8'hED, 8'hA0, 8'h80,
        8'hF5, 8'h80, 8'h80, 8'h80,
        8'hE2, 8'h82, 8'h00
    };

    utf8_validating_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    utf8_decode_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int   gap;
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one text byte, with an optional idle burst first, and hold until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    task automatic write_store_limit(input logic [15:0] value);
        wait_drained();
        // a pending byte owes nothing, so give the pipeline time to go quiet
        repeat (SETTLE) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Send the first count bytes of cp encoded in len bytes, range not enforced
    task automatic send_encoded(input logic [20:0] cp, input int len, input int count);
        logic [31:0] seq;
        int          i;
        case (len)
            1:       seq = {24'd0, 1'b0, cp[6:0]};
            2:       seq = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            3:       seq = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            default: seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                            5'b11110, cp[20:18]};
        endcase
        for (i = 0; i < count; i++)
            send_byte(seq[8*i +: 8]);
    endtask

    function automatic logic [20:0] valid_scalar(input int len);
        logic [20:0] cp;
        case (len)
            1:       cp = 21'($urandom_range(1, 127));
            2:       cp = 21'($urandom_range(128, 2047));
            3:
            begin
                cp = 21'($urandom_range(2048, 65535));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h002000;
            end
            default: cp = 21'($urandom_range(65536, 1114111));
        endcase
        return cp;
    endfunction

    // Mostly well-formed sequences, some cut short, some malformed, some noise
    task automatic send_random_text(input int budget);
        int          sent;
        int          pick;
        int          len;
        int          n;
        logic [7:0]  b;
        logic [20:0] cp;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(1, 4);
                send_encoded(valid_scalar(len), len, len);
                sent = sent + len;
            end
            else if (pick < 70)
            begin
                // truncated sequence broken by a non-continuation
                len = $urandom_range(2, 4);
                n   = $urandom_range(1, len - 1);
                send_encoded(valid_scalar(len), len, n);
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[7] = 1'b0;
                send_byte(b);
                sent = sent + n + 1;
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // overlong
                        len = $urandom_range(2, 4);
                        if (len == 2)
                            cp = 21'($urandom_range(0, 127));
                        else if (len == 3)
                            cp = 21'($urandom_range(0, 2047));
                        else
                            cp = 21'($urandom_range(0, 65535));
                    end
                    1:
                    begin
                        len = 3;
                        cp  = 21'($urandom_range(SURR_LO, SURR_HI));
                    end
                    default:
                    begin
                        len = 4;
                        cp  = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                    end
                endcase
                send_encoded(cp, len, len);
                sent = sent + len;
            end
            else if (pick < 94)
            begin
                send_byte(8'($urandom_range(1, 255)));
                sent = sent + 1;
            end
            else
            begin
                send_byte(8'h00);
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 16'd0;
        src_idle_en   <= 1'b1;
        sink_idle_en  <= 1'b1;
        hold_req      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening text under the reset limit
        for (i = 0; i < 24; i++)
            send_byte(opening_text[i]);

        // No point is ever within a zero limit
        write_store_limit(16'd0);
        send_random_text(130);

        // Back up the block behind a long result stall, then drain fully
        src_idle_en <= 1'b0;
        hold_req    <= 1'b1;
        send_random_text(30);
        wait_drained();
        src_idle_en <= 1'b1;

        // Small limit so the flag flips inside most texts
        write_store_limit(16'd3);
        send_random_text(100);

        // Closing stretch at full rate
        src_idle_en  <= 1'b0;
        sink_idle_en <= 1'b0;
        write_store_limit(16'($urandom_range(1, 40)));
        send_random_text(90);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
